/* hw/rtl/prot_pkg.sv */
// Shared types, constants and the arctangent table for the point rotation block.
`default_nettype none

package prot_pkg;

    // Default build values for the top-level parameters
    localparam int CORDIC_STAGES_DEF = 16;
    localparam int FRAC_BITS_DEF     = 16;

    // Port and field widths
    localparam int COORD_W     = 32;
    localparam int IN_DATA_W   = 5 * COORD_W;
    localparam int OUT_DATA_W  = 2 * COORD_W;
    localparam int OUT_USER_W  = 1;

    // Datapath widths
    localparam int DIFF_W      = COORD_W + 1;        // point - pivot, never wraps
    localparam int ANGLE_W     = 32;                 // binary angle, 2^32 per turn
    localparam int XY_W        = 32;                 // CORDIC x/y, 30 fraction bits
    localparam int CS_W        = 31;                 // cos/sin, 28 fraction bits
    localparam int PROD_W      = DIFF_W + CS_W;
    localparam int ROUND_SHIFT = 28;
    localparam int OFF_W       = PROD_W - ROUND_SHIFT;
    localparam int SUM_W       = OFF_W + 1;

    // Angle reduction: ang = 360*A + g, worked out through u2 = ang + 360*ANGLE_BIAS
    localparam int U2_W         = COORD_W + 1;
    localparam int QUOT_W       = 25;
    localparam int REM_W        = 9;
    localparam int DIVN_W       = 30;
    localparam int PRE_SHIFT    = 3;                 // 360 = 8 * 45
    localparam int DEG_TURN     = 360;
    localparam int DEG_ROUND_PRE = (DEG_TURN / 2) / (1 << PRE_SHIFT);
    localparam logic [QUOT_W-1:0] ANGLE_BIAS   = 25'd5965233;
    localparam logic [U2_W-1:0]   ANGLE_OFFSET = 33'd2147483880;   // 360 * ANGLE_BIAS
    localparam int RECIP_W      = 31;
    localparam logic [RECIP_W-1:0] RECIP45     = 31'd1527099484;  // ceil(2^36 / 45)
    localparam int RECIP_SHIFT  = 36;
    localparam int RECIP_PROD_W = DIVN_W + RECIP_W;
    localparam int ANGLE_LAT    = 5;

    localparam logic [ANGLE_W-1:0] TURN_QUARTER = 32'h4000_0000;
    localparam logic [ANGLE_W-1:0] TURN_HALF    = 32'h8000_0000;

    localparam logic signed [XY_W-1:0]    CORDIC_GAIN = 32'sd652032874;
    localparam logic signed [COORD_W-1:0] COORD_MAX   = 32'sh7FFF_FFFF;
    localparam logic signed [COORD_W-1:0] COORD_MIN   = 32'sh8000_0000;

    // Folded binary angle handed to the CORDIC
    typedef struct packed {
        logic                      neg;
        logic signed [ANGLE_W-1:0] z;
    } bang_t;

    typedef struct packed {
        logic signed [CS_W-1:0] cos_v;
        logic signed [CS_W-1:0] sin_v;
    } trig_t;

    typedef struct packed {
        logic signed [DIFF_W-1:0]  dx;
        logic signed [DIFF_W-1:0]  dy;
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
    } offset_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] rot_x;
        logic signed [COORD_W-1:0] rot_y;
        logic                      overflow;
    } result_t;

    // atan(2^-i) in binary-angle units, rounded to nearest
    function automatic logic signed [ANGLE_W-1:0] atan_turn(input int unsigned idx);
        case (idx)
            0:  atan_turn = 32'sd536870912;
            1:  atan_turn = 32'sd316933406;
            2:  atan_turn = 32'sd167458907;
            3:  atan_turn = 32'sd85004756;
            4:  atan_turn = 32'sd42667331;
            5:  atan_turn = 32'sd21354465;
            6:  atan_turn = 32'sd10679838;
            7:  atan_turn = 32'sd5340245;
            8:  atan_turn = 32'sd2670163;
            9:  atan_turn = 32'sd1335087;
            10: atan_turn = 32'sd667544;
            11: atan_turn = 32'sd333772;
            12: atan_turn = 32'sd166886;
            13: atan_turn = 32'sd83443;
            14: atan_turn = 32'sd41722;
            15: atan_turn = 32'sd20861;
            16: atan_turn = 32'sd10430;
            17: atan_turn = 32'sd5215;
            18: atan_turn = 32'sd2608;
            19: atan_turn = 32'sd1304;
            20: atan_turn = 32'sd652;
            21: atan_turn = 32'sd326;
            22: atan_turn = 32'sd163;
            23: atan_turn = 32'sd81;
            24: atan_turn = 32'sd41;
            25: atan_turn = 32'sd20;
            26: atan_turn = 32'sd10;
            27: atan_turn = 32'sd5;
            28: atan_turn = 32'sd3;
            29: atan_turn = 32'sd1;
            default: atan_turn = '0;
        endcase
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/prot_angle.sv */
// Angle reduction: degrees modulo 360 to a folded 32-bit binary angle, five stages.
`default_nettype none

module prot_angle #(
    parameter int FRAC_BITS = prot_pkg::FRAC_BITS_DEF
) (
    input  wire                                 aclk,
    input  wire                                 aresetn,
    input  wire                                 en,
    input  wire                                 in_valid,
    input  wire logic signed [prot_pkg::ANGLE_W-1:0] angle,
    output logic                                out_valid,
    output prot_pkg::bang_t                     out_ang
);
    import prot_pkg::*;

    localparam int TURN_SHIFT = ANGLE_W - FRAC_BITS;

    logic [ANGLE_LAT-1:0]       vld_reg;
    logic [U2_W-1:0]            u2_reg, u2_next;
    logic [RECIP_PROD_W-1:0]    quot_prod_reg, quot_prod_next;
    logic [REM_W-1:0]           low_reg;
    logic [QUOT_W-1:0]          quot;
    logic [REM_W-1:0]           rem_next;
    logic [FRAC_BITS-1:0]       turns_reg, turns_next, turns2_reg;
    logic [DIVN_W-1:0]          frac_num_reg, frac_num_next;
    logic [RECIP_PROD_W-1:0]    frac_prod_reg, frac_prod_next;
    logic [TURN_SHIFT-1:0]      frac_turn;
    logic [ANGLE_W-1:0]         bang, bang_chk;
    bang_t                      ang_reg, ang_next;

    // Stage 1: offset the angle so it is never negative
    assign u2_next = U2_W'(angle) + ANGLE_OFFSET;

    // Stage 2: quotient by 360 as (u2 / 8) * ceil(2^36 / 45)
    assign quot_prod_next = RECIP_PROD_W'(u2_reg[U2_W-1:PRE_SHIFT]) * RECIP_PROD_W'(RECIP45);

    // Stage 3: whole turns (low bits only) and remainder degrees g
    always_comb begin
        quot          = quot_prod_reg[RECIP_SHIFT +: QUOT_W];
        rem_next      = low_reg - REM_W'(quot[REM_W-1:0] * REM_W'(DEG_TURN));
        turns_next    = FRAC_BITS'(quot - ANGLE_BIAS);
        frac_num_next = (DIVN_W'(rem_next) << (TURN_SHIFT - PRE_SHIFT))
                        + DIVN_W'(DEG_ROUND_PRE);
    end

    // Stage 4: fraction of a turn, floor((g * 2^k + 180) / 360)
    assign frac_prod_next = RECIP_PROD_W'(frac_num_reg) * RECIP_PROD_W'(RECIP45);

    // Stage 5: assemble binary angle and fold into [-90, 90) degrees
    always_comb begin
        frac_turn    = frac_prod_reg[RECIP_SHIFT +: TURN_SHIFT];
        bang         = {turns2_reg, frac_turn};
        bang_chk     = bang + TURN_QUARTER;
        ang_next.neg = bang_chk[ANGLE_W-1];
        ang_next.z   = ang_next.neg ? $signed(bang ^ TURN_HALF) : $signed(bang);
    end

    // Valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[ANGLE_LAT-2:0], in_valid};
        end
    end

    // Payload stages
    always_ff @(posedge aclk) begin
        if (en) begin
            u2_reg        <= u2_next;
            quot_prod_reg <= quot_prod_next;
            low_reg       <= u2_reg[REM_W-1:0];
            turns_reg     <= turns_next;
            frac_num_reg  <= frac_num_next;
            turns2_reg    <= turns_reg;
            frac_prod_reg <= frac_prod_next;
            ang_reg       <= ang_next;
        end
    end

    assign out_valid = vld_reg[ANGLE_LAT-1];
    assign out_ang   = ang_reg;

`ifndef SYNTHESIS
    a_rem_range: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[1] |-> (rem_next < REM_W'(DEG_TURN)))
        else $error("angle remainder out of range");

    a_fold_range: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[ANGLE_LAT-1] |-> (ang_reg.z[ANGLE_W-1] == ang_reg.z[ANGLE_W-2]))
        else $error("folded angle outside half turn");
`endif

endmodule

`default_nettype wire

/* hw/rtl/prot_cordic.sv */
// Unrolled rotation-mode CORDIC, one register stage per iteration, plus a rounding stage.
`default_nettype none

module prot_cordic #(
    parameter int STAGES = prot_pkg::CORDIC_STAGES_DEF
) (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire                   en,
    input  wire                   in_valid,
    input  wire prot_pkg::bang_t  in_ang,
    output logic                  out_valid,
    output prot_pkg::trig_t       out_trig
);
    import prot_pkg::*;

    logic signed [XY_W-1:0]    x_reg [STAGES];
    logic signed [XY_W-1:0]    y_reg [STAGES];
    logic signed [ANGLE_W-1:0] z_reg [STAGES];
    logic [STAGES-1:0]         vld_reg;
    logic [STAGES-1:0]         neg_reg;
    logic signed [XY_W:0]      cos_sum, sin_sum;
    trig_t                     trig_reg, trig_next;
    logic                      out_vld_reg;

    // One micro-rotation per stage
    for (genvar i = 0; i < STAGES; i++) begin : g_stage
        logic signed [XY_W-1:0]    x_in, y_in, x_next, y_next;
        logic signed [ANGLE_W-1:0] z_in, z_next;

        if (i == 0) begin : g_first
            assign x_in = CORDIC_GAIN;
            assign y_in = '0;
            assign z_in = in_ang.z;
        end else begin : g_rest
            assign x_in = x_reg[i-1];
            assign y_in = y_reg[i-1];
            assign z_in = z_reg[i-1];
        end

        always_comb begin
            if (!z_in[ANGLE_W-1]) begin
                x_next = x_in - (y_in >>> i);
                y_next = y_in + (x_in >>> i);
                z_next = z_in - atan_turn(i);
            end else begin
                x_next = x_in + (y_in >>> i);
                y_next = y_in - (x_in >>> i);
                z_next = z_in + atan_turn(i);
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                x_reg[i] <= x_next;
                y_reg[i] <= y_next;
                z_reg[i] <= z_next;
            end
        end
    end

    // Undo the fold (negate) and round to 28 fraction bits: -v + 2 == ~v + 3
    always_comb begin
        cos_sum = neg_reg[STAGES-1] ? (~(XY_W+1)'(x_reg[STAGES-1]) + (XY_W+1)'(3))
                                    : ((XY_W+1)'(x_reg[STAGES-1]) + (XY_W+1)'(2));
        sin_sum = neg_reg[STAGES-1] ? (~(XY_W+1)'(y_reg[STAGES-1]) + (XY_W+1)'(3))
                                    : ((XY_W+1)'(y_reg[STAGES-1]) + (XY_W+1)'(2));
        trig_next.cos_v = cos_sum[XY_W:2];
        trig_next.sin_v = sin_sum[XY_W:2];
    end

    // Valid and fold bits travel with the stages
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg     <= '0;
            out_vld_reg <= 1'b0;
        end else if (en) begin
            vld_reg     <= {vld_reg[STAGES-2:0], in_valid};
            out_vld_reg <= vld_reg[STAGES-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            neg_reg  <= {neg_reg[STAGES-2:0], in_ang.neg};
            trig_reg <= trig_next;
        end
    end

    assign out_valid = out_vld_reg;
    assign out_trig  = trig_reg;

`ifndef SYNTHESIS
    a_trig_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        out_vld_reg |-> ((trig_reg.cos_v[CS_W-1] == trig_reg.cos_v[CS_W-2]) &&
                         (trig_reg.sin_v[CS_W-1] == trig_reg.sin_v[CS_W-2])))
        else $error("cos/sin magnitude beyond unit range");
`endif

endmodule

`default_nettype wire

/* hw/rtl/prot_rotate.sv */
// Rotation products, rounding, pivot add and saturation in three stages.
`default_nettype none

module prot_rotate (
    input  wire                     aclk,
    input  wire                     aresetn,
    input  wire                     en,
    input  wire                     in_valid,
    input  wire prot_pkg::trig_t    trig,
    input  wire prot_pkg::offset_t  ofs,
    output logic                    out_valid,
    output prot_pkg::result_t       out_res
);
    import prot_pkg::*;

    localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (ROUND_SHIFT - 1);

    logic [2:0]                 vld_reg;
    logic signed [PROD_W-1:0]   p_xc_reg, p_ys_reg, p_xs_reg, p_yc_reg;
    logic signed [PROD_W-1:0]   p_xc_next, p_ys_next, p_xs_next, p_yc_next;
    logic signed [COORD_W-1:0]  cx1_reg, cy1_reg, cx2_reg, cy2_reg;
    logic signed [PROD_W-1:0]   sum_x, sum_y;
    logic signed [OFF_W-1:0]    off_x_reg, off_y_reg, off_x_next, off_y_next;
    logic signed [SUM_W-1:0]    full_x, full_y;
    logic                       ovf_x, ovf_y;
    result_t                    res_reg, res_next;

    // Stage 1: four products
    always_comb begin
        p_xc_next = PROD_W'(ofs.dx) * PROD_W'(trig.cos_v);
        p_ys_next = PROD_W'(ofs.dy) * PROD_W'(trig.sin_v);
        p_xs_next = PROD_W'(ofs.dx) * PROD_W'(trig.sin_v);
        p_yc_next = PROD_W'(ofs.dy) * PROD_W'(trig.cos_v);
    end

    // Stage 2: combine and round half up to integer Q16.16 offset
    always_comb begin
        sum_x      = p_xc_reg - p_ys_reg + ROUND_HALF;
        sum_y      = p_xs_reg + p_yc_reg + ROUND_HALF;
        off_x_next = sum_x[PROD_W-1:ROUND_SHIFT];
        off_y_next = sum_y[PROD_W-1:ROUND_SHIFT];
    end

    // Stage 3: add pivot and saturate to 32 bits
    always_comb begin
        full_x = SUM_W'(cx2_reg) + SUM_W'(off_x_reg);
        full_y = SUM_W'(cy2_reg) + SUM_W'(off_y_reg);
        ovf_x  = (full_x[SUM_W-1:COORD_W-1] != '0) && (full_x[SUM_W-1:COORD_W-1] != '1);
        ovf_y  = (full_y[SUM_W-1:COORD_W-1] != '0) && (full_y[SUM_W-1:COORD_W-1] != '1);
        res_next.rot_x    = ovf_x ? (full_x[SUM_W-1] ? COORD_MIN : COORD_MAX)
                                  : full_x[COORD_W-1:0];
        res_next.rot_y    = ovf_y ? (full_y[SUM_W-1] ? COORD_MIN : COORD_MAX)
                                  : full_y[COORD_W-1:0];
        res_next.overflow = ovf_x | ovf_y;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[1:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p_xc_reg  <= p_xc_next;
            p_ys_reg  <= p_ys_next;
            p_xs_reg  <= p_xs_next;
            p_yc_reg  <= p_yc_next;
            cx1_reg   <= ofs.cx;
            cy1_reg   <= ofs.cy;
            off_x_reg <= off_x_next;
            off_y_reg <= off_y_next;
            cx2_reg   <= cx1_reg;
            cy2_reg   <= cy1_reg;
            res_reg   <= res_next;
        end
    end

    assign out_valid = vld_reg[2];
    assign out_res   = res_reg;

`ifndef SYNTHESIS
    a_ovf_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        (vld_reg[2] && res_reg.overflow) |->
            (res_reg.rot_x == COORD_MAX || res_reg.rot_x == COORD_MIN ||
             res_reg.rot_y == COORD_MAX || res_reg.rot_y == COORD_MIN))
        else $error("overflow flagged without a saturated coordinate");
`endif

endmodule

`default_nettype wire

/* hw/rtl/prot_outbuf.sv */
// Output register with a skid word; its full flag stalls the whole pipeline.
`default_nettype none

module prot_outbuf (
    input  wire                     aclk,
    input  wire                     aresetn,
    input  wire                     in_valid,
    input  wire prot_pkg::result_t  in_res,
    output logic                    in_ready,
    output logic                    out_valid,
    input  wire                     out_ready,
    output prot_pkg::result_t       out_res
);
    import prot_pkg::*;

    logic    out_vld_reg, out_vld_next;
    logic    skid_full_reg, skid_full_next;
    result_t out_res_reg, out_res_next;
    result_t skid_res_reg, skid_res_next;

    // Output slot refills from the skid word first, then from the pipeline
    always_comb begin
        out_vld_next   = out_vld_reg;
        out_res_next   = out_res_reg;
        skid_full_next = skid_full_reg;
        skid_res_next  = skid_res_reg;
        if (!out_vld_reg || out_ready) begin
            if (skid_full_reg) begin
                out_vld_next   = 1'b1;
                out_res_next   = skid_res_reg;
                skid_full_next = 1'b0;
            end else if (in_valid) begin
                out_vld_next   = 1'b1;
                out_res_next   = in_res;
            end else begin
                out_vld_next   = 1'b0;
            end
        end else if (in_valid && !skid_full_reg) begin
            skid_full_next = 1'b1;
            skid_res_next  = in_res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg   <= 1'b0;
            skid_full_reg <= 1'b0;
        end else begin
            out_vld_reg   <= out_vld_next;
            skid_full_reg <= skid_full_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_res_reg  <= out_res_next;
        skid_res_reg <= skid_res_next;
    end

    assign in_ready  = !skid_full_reg;
    assign out_valid = out_vld_reg;
    assign out_res   = out_res_reg;

`ifndef SYNTHESIS
    a_skid_order: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_full_reg |-> out_vld_reg)
        else $error("skid word held while output slot empty");
`endif

endmodule

`default_nettype wire

/* hw/rtl/point_rotation_about_pivot_top.sv */
// Path to m_tvalid: input register, angle reduction, CORDIC, rotation, output buffer.
// Throughput: one word per cycle; every stage is a register, the CORDIC is fully unrolled.
// s_tready is low only while the output skid word is occupied; the pipeline then holds.
// Reset (aresetn low, synchronous) clears all valid bits and the skid flag;
// payload registers are not reset and the block keeps no state between words.
`default_nettype none

module point_rotation_about_pivot_top #(
    parameter int CORDIC_STAGES = prot_pkg::CORDIC_STAGES_DEF,
    parameter int FRAC_BITS     = prot_pkg::FRAC_BITS_DEF
) (
    input  wire                                aclk,
    input  wire                                aresetn,
    input  wire                                s_tvalid,
    output logic                               s_tready,
    input  wire [prot_pkg::IN_DATA_W-1:0]      s_tdata,  // point_x, point_y, pivot_x,
                                                         // pivot_y, angle_deg
    output logic                               m_tvalid,
    input  wire                                m_tready,
    output logic [prot_pkg::OUT_DATA_W-1:0]    m_tdata,  // rot_x, rot_y
    output logic [prot_pkg::OUT_USER_W-1:0]    m_tuser   // overflow
);
    import prot_pkg::*;

    localparam int DLY = 1 + ANGLE_LAT + CORDIC_STAGES + 1;

    logic                      en;
    logic                      in_vld_reg;
    logic signed [ANGLE_W-1:0] ang_reg;
    offset_t                   ofs_next;
    offset_t                   ofs_dly_reg [DLY];
    logic                      ang_vld, trig_vld, rot_vld;
    bang_t                     bang;
    trig_t                     trig;
    result_t                   rot_res, out_res;

    // Unpack the input word and form point - pivot at full width
    always_comb begin
        ofs_next.cx = $signed(s_tdata[2*COORD_W +: COORD_W]);
        ofs_next.cy = $signed(s_tdata[3*COORD_W +: COORD_W]);
        ofs_next.dx = DIFF_W'($signed(s_tdata[0 +: COORD_W])) - DIFF_W'(ofs_next.cx);
        ofs_next.dy = DIFF_W'($signed(s_tdata[COORD_W +: COORD_W])) - DIFF_W'(ofs_next.cy);
    end

    // Input stage valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (en) begin
            in_vld_reg <= s_tvalid;
        end
    end

    // Angle register and offset delay line matched to the angle + CORDIC depth
    always_ff @(posedge aclk) begin
        if (en) begin
            ang_reg        <= $signed(s_tdata[4*COORD_W +: COORD_W]);
            ofs_dly_reg[0] <= ofs_next;
            for (int i = 1; i < DLY; i++) begin
                ofs_dly_reg[i] <= ofs_dly_reg[i-1];
            end
        end
    end

    prot_angle #(
        .FRAC_BITS (FRAC_BITS)
    ) u_angle (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (in_vld_reg),
        .angle     (ang_reg),
        .out_valid (ang_vld),
        .out_ang   (bang)
    );

    prot_cordic #(
        .STAGES (CORDIC_STAGES)
    ) u_cordic (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (ang_vld),
        .in_ang    (bang),
        .out_valid (trig_vld),
        .out_trig  (trig)
    );

    prot_rotate u_rotate (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (trig_vld),
        .trig      (trig),
        .ofs       (ofs_dly_reg[DLY-1]),
        .out_valid (rot_vld),
        .out_res   (rot_res)
    );

    prot_outbuf u_outbuf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (rot_vld),
        .in_res    (rot_res),
        .in_ready  (en),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    assign s_tready = en;
    assign m_tdata  = {out_res.rot_y, out_res.rot_x};
    assign m_tuser  = out_res.overflow;

endmodule

`default_nettype wire

/* tb/tb_point_rotation_about_pivot_top.sv */
// Self-checking testbench for the point rotation block: directed table, then random words.
`default_nettype none

module tb_point_rotation_about_pivot_top;

    import prot_pkg::*;

    localparam int STAGES  = CORDIC_STAGES_DEF;
    localparam int FRAC    = FRAC_BITS_DEF;
    localparam int LATENCY = STAGES + 11;
    localparam int DEG     = 1 << FRAC;
    localparam int RANDOM_WORDS   = 850;
    localparam int WATCHDOG_LIMIT = 4000;

    localparam logic signed [COORD_W-1:0] CMAX = COORD_MAX;
    localparam logic signed [COORD_W-1:0] CMIN = COORD_MIN;
    localparam longint SAT_HI = 64'sd2147483647;
    localparam longint SAT_LO = -64'sd2147483648;
    localparam longint Q30_GAIN = 64'sd652032874;

    // arctangent of 2^-i, binary-angle units
    localparam longint ARCTAN [30] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
        41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
        10, 5, 3, 1
    };

    typedef struct packed {
        logic signed [COORD_W-1:0] px;
        logic signed [COORD_W-1:0] py;
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
        logic signed [COORD_W-1:0] ang;
        logic                      typed;   // want holds the expected word
        result_t                   want;
    } stim_row_t;

    localparam result_t NONE = '0;
    localparam int N_DIRECTED = 23;

    // px, py, cx, cy, angle, typed, expected
    localparam stim_row_t DIRECTED [N_DIRECTED] = '{
        '{0, 0, 0, 0, 0, 1'b0, NONE},
        // point on the pivot stays put
        '{0, 0, 0, 0, 90*DEG, 1'b1, '{0, 0, 1'b0}},
        '{CMAX, CMAX, CMAX, CMAX, CMIN, 1'b1, '{CMAX, CMAX, 1'b0}},
        '{CMIN, CMIN, CMIN, CMIN, CMAX, 1'b1, '{CMIN, CMIN, 1'b0}},
        // zero and tiny angles keep the residual gain error
        '{DEG, 0, 0, 0, 0, 1'b0, NONE},
        '{DEG, 0, 0, 0, 1, 1'b0, NONE},
        '{DEG, 0, 0, 0, -1, 1'b0, NONE},
        // quadrant and fold boundaries, whole turns
        '{DEG, 0, 0, 0, 90*DEG, 1'b0, NONE},
        '{DEG, 0, 0, 0, 180*DEG, 1'b0, NONE},
        '{DEG, 0, 0, 0, 270*DEG, 1'b0, NONE},
        '{DEG, 0, 0, 0, -90*DEG, 1'b0, NONE},
        '{DEG, 0, 0, 0, 360*DEG, 1'b0, NONE},
        '{DEG, 0, 0, 0, 720*DEG, 1'b0, NONE},
        '{3*DEG, -2*DEG, DEG, DEG, 45*DEG, 1'b0, NONE},
        '{3*DEG, -2*DEG, DEG, DEG, -45*DEG, 1'b0, NONE},
        '{100*DEG, 50*DEG, -20*DEG, 7*DEG, 90*DEG - 1, 1'b0, NONE},
        '{5*DEG, 5*DEG, 0, 0, CMIN, 1'b0, NONE},
        '{5*DEG, 5*DEG, 0, 0, CMAX, 1'b0, NONE},
        // wide point - pivot, one coordinate runs out of range
        '{CMAX, 0, CMIN, 0, 90*DEG, 1'b0, NONE},
        // both coordinates saturate
        '{CMAX, CMAX, CMIN, CMIN, 180*DEG, 1'b1, '{CMIN, CMIN, 1'b1}},
        '{CMIN, CMIN, CMAX, CMAX, 180*DEG, 1'b1, '{CMAX, CMAX, 1'b1}},
        '{CMAX, CMIN, 0, 0, 30*DEG, 1'b0, NONE},
        '{-15*DEG/2, 49*DEG/4, -3*DEG, 4*DEG, 271*DEG/2, 1'b0, NONE}
    };

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [OUT_USER_W-1:0] m_tuser;

    result_t pending_results [$];
    int      mismatches  = 0;
    bit      quiet_phase = 1'b0;
    int      stall_left  = 0;

    wire in_fire  = s_tvalid && s_tready;
    wire out_fire = m_tvalid && m_tready;

    point_rotation_about_pivot_top #(
        .CORDIC_STAGES(STAGES),
        .FRAC_BITS    (FRAC)
    ) uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    always #10 aclk = ~aclk;

    // Expected rotated point: reduce angle, fold, CORDIC, round, multiply, saturate
    function automatic result_t rotate_about_pivot(
        input logic signed [COORD_W-1:0] px, py, cx, cy, ang
    );
        longint      turn_fx, red, quot, x, y, z, nx, cos_q, sin_q, dx, dy, rx, ry;
        logic [31:0] bang;
        logic        flip;
        result_t     res;
        turn_fx = longint'(DEG_TURN) << FRAC;
        red = longint'(ang) % turn_fx;
        if (red < 0) red += turn_fx;
        quot = ((red << (32 - FRAC)) + (DEG_TURN / 2)) / DEG_TURN;
        bang = quot[31:0];
        flip = 1'b0;
        if (((bang + TURN_QUARTER) & TURN_HALF) != 0) begin
            bang = bang + TURN_HALF;
            flip = 1'b1;
        end
        z = longint'(signed'(bang));
        x = Q30_GAIN;
        y = 0;
        for (int i = 0; i < STAGES && i < 30; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> i);
                y  = y + (x >>> i);
                z  = z - ARCTAN[i];
            end else begin
                nx = x + (y >>> i);
                y  = y - (x >>> i);
                z  = z + ARCTAN[i];
            end
            x = nx;
        end
        if (flip) begin
            x = -x;
            y = -y;
        end
        cos_q = (x + 2) >>> 2;
        sin_q = (y + 2) >>> 2;
        dx = longint'(px) - longint'(cx);
        dy = longint'(py) - longint'(cy);
        rx = longint'(cx) + ((dx * cos_q - dy * sin_q + (longint'(1) << 27)) >>> 28);
        ry = longint'(cy) + ((dx * sin_q + dy * cos_q + (longint'(1) << 27)) >>> 28);
        res.overflow = 1'b0;
        if (rx > SAT_HI) begin
            rx = SAT_HI;
            res.overflow = 1'b1;
        end else if (rx < SAT_LO) begin
            rx = SAT_LO;
            res.overflow = 1'b1;
        end
        if (ry > SAT_HI) begin
            ry = SAT_HI;
            res.overflow = 1'b1;
        end else if (ry < SAT_LO) begin
            ry = SAT_LO;
            res.overflow = 1'b1;
        end
        res.rot_x = rx[31:0];
        res.rot_y = ry[31:0];
        return res;
    endfunction

    // mostly short idle stretches, now and then a long one
    function automatic int idle_length();
        int pick;
        pick = $urandom_range(99);
        if (pick < 75) return $urandom_range(1, 3);
        if (pick < 94) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // coordinates: small, mid-range or full-range
    function automatic logic signed [COORD_W-1:0] rand_coord();
        logic signed [COORD_W-1:0] v;
        int pick;
        v = $urandom;
        pick = $urandom_range(99);
        if (pick < 35) return v >>> 12;
        if (pick < 65) return v >>> 4;
        return v;
    endfunction

    // angles: full-range, a few turns, near multiples of 45 degrees, near zero
    function automatic logic signed [COORD_W-1:0] rand_angle();
        logic signed [COORD_W-1:0] v;
        int pick;
        v = $urandom;
        pick = $urandom_range(99);
        if (pick < 35) return v;
        if (pick < 65) return v >>> 6;
        if (pick < 90) return 45 * DEG * (int'($urandom_range(32)) - 16)
                              + (int'($urandom_range(6)) - 3);
        return int'($urandom_range(32)) - 16;
    endfunction

    // Offer one word after an optional gap and log its expected result on acceptance
    task automatic offer_word(input stim_row_t r);
        int gap;
        gap = 0;
        if (!quiet_phase && $urandom_range(99) < 35) gap = idle_length();
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tdata  <= {r.ang, r.cy, r.cx, r.py, r.px};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        if (r.typed) pending_results.push_back(r.want);
        else pending_results.push_back(rotate_about_pivot(r.px, r.py, r.cx, r.cy, r.ang));
    endtask

    // Result side back-pressure
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else if (!quiet_phase && $urandom_range(99) < 20) begin
            stall_left <= idle_length() - 1;
            m_tready   <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Compare each result word with the oldest expectation
    always @(posedge aclk) begin : result_check
        result_t got, want;
        if (aresetn && out_fire) begin
            got.rot_x    = m_tdata[COORD_W-1:0];
            got.rot_y    = m_tdata[2*COORD_W-1:COORD_W];
            got.overflow = m_tuser[0];
            if (pending_results.size() == 0) begin
                $error("result word with nothing expected: rot_x %0d rot_y %0d",
                       got.rot_x, got.rot_y);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                if (got.rot_x !== want.rot_x) begin
                    $error("rot_x: expected %0d, got %0d", want.rot_x, got.rot_x);
                    mismatches++;
                end
                if (got.rot_y !== want.rot_y) begin
                    $error("rot_y: expected %0d, got %0d", want.rot_y, got.rot_y);
                    mismatches++;
                end
                if (got.overflow !== want.overflow) begin
                    $error("overflow: expected %0b, got %0b", want.overflow, got.overflow);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: too long without any word moving on either side
    initial begin : watchdog
        int idle;
        idle = 0;
        while (idle < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if (in_fire || out_fire) idle = 0;
            else idle++;
        end
        $display("simulation failed");
        $finish;
    end

    // Stimulus
    initial begin : stimulus
        stim_row_t r;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (DIRECTED[i]) offer_word(DIRECTED[i]);

        for (int k = 0; k < RANDOM_WORDS; k++) begin
            // every 200 words, a 40-word stretch at full rate on both sides
            quiet_phase = (k % 200) >= 160;
            r.px    = rand_coord();
            r.py    = rand_coord();
            r.cx    = rand_coord();
            r.cy    = rand_coord();
            r.ang   = rand_angle();
            r.typed = 1'b0;
            r.want  = NONE;
            offer_word(r);
        end
        quiet_phase = 1'b0;
        @(negedge aclk);
        s_tvalid <= 1'b0;

        // drain, then watch for stray words
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (LATENCY + 8) @(posedge aclk);
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
